// ===== sv/ssim_dissimilarity_map_defines.svh =====
// Assertion macros used by the ssim_dissimilarity_map module.
`ifndef SSIM_DISSIMILARITY_MAP_DEFINES_SVH
`define SSIM_DISSIMILARITY_MAP_DEFINES_SVH

`ifndef SYNTHESIS
`define SDM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdm check failed");
`define SDM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdm check failed");
`else
`define SDM_ASSERT_IMP(lbl, ante, cons)
`define SDM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/sdm_pkg.sv =====
`timescale 1ns / 1ps

package sdm_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // long division chain geometry
    localparam int DIV_STEPS = 34;
    localparam int DVD_W     = 34;
    localparam int DVS_W     = 51;
    localparam int REM_W     = 52;

    localparam logic [DVS_W-1:0] TERM_MEAN_DIV = 51'd65025;
    localparam logic [DVS_W-1:0] TERM_VAR_DIV  = 51'd255;

    localparam logic signed [17:0] PEAK_RESET = -18'sd65536;

    typedef enum logic [2:0] {
        TAG_P1,
        TAG_Q1,
        TAG_P2,
        TAG_Q2,
        TAG_FRAC,
        TAG_LINE,
        TAG_FRAME
    } div_tag_t;

    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_C1,
        REG_C2
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        div_tag_t         tag;
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
        logic [DVS_W-1:0] dvs;
    } div_job_t;

endpackage

// ===== sv/sdm_div_cell.sv =====
`timescale 1ns / 1ps

// One restoring step: shift in the next dividend bit, subtract when it fits.
module sdm_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  sdm_pkg::div_job_t job_in,
    output sdm_pkg::div_job_t job_out
);

    sdm_pkg::div_job_t             job_reg;
    sdm_pkg::div_job_t             job_next;
    logic [sdm_pkg::REM_W-1:0]     shifted;
    logic                          fits;

    always_comb
    begin
        shifted  = {job_in.rem[sdm_pkg::REM_W-2:0], job_in.dvd[sdm_pkg::DVD_W-1]};
        fits     = (shifted >= {1'b0, job_in.dvs});
        job_next = job_in;
        job_next.rem = fits ? (shifted - {1'b0, job_in.dvs}) : shifted;
        job_next.dvd = {job_in.dvd[sdm_pkg::DVD_W-2:0], 1'b0};
        job_next.quo = {job_in.quo[sdm_pkg::DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg <= '0;
        end
        else
        begin
            job_reg <= job_next;
        end
    end

    assign job_out = job_reg;

endmodule

// ===== sv/sdm_div_chain.sv =====
`timescale 1ns / 1ps

// Row of DIV_STEPS division cells; a job can enter each cycle and passes through every cell.
module sdm_div_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  sdm_pkg::div_job_t job_in,
    output sdm_pkg::div_job_t job_out
);

    sdm_pkg::div_job_t link [0:sdm_pkg::DIV_STEPS];

    assign link[0] = job_in;

    for (genvar i = 0; i < sdm_pkg::DIV_STEPS; i++)
    begin : g_cell
        sdm_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .job_in  (link[i]),
            .job_out (link[i+1])
        );
    end

    assign job_out = link[sdm_pkg::DIV_STEPS];

endmodule

// ===== sv/ssim_dissimilarity_map.sv =====
`timescale 1ns / 1ps

// DSSIM map over a raster pixel stream. Each item brings two local means,
// two variances and a covariance (all v/255); the block returns one item per
// input with trunc(DSSIM*255), and on the last pixel of a frame the frame
// mean and peak DSSIM in signed Q1.16. One item is worked on at a time:
// every division (the four SSIM terms, the DSSIM fraction, the line average
// and the frame average) runs through a 34-cell long-division chain, the
// four terms back to back. A zero denominator or a saturated fraction skips
// the DSSIM division. A new item is taken while the previous result still
// waits in the output register. Registers may be written only while the
// block is idle.
`include "ssim_dissimilarity_map_defines.svh"

module ssim_dissimilarity_map (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          mean_first,
    input  logic [7:0]          mean_second,
    input  logic [7:0]          var_first,
    input  logic [7:0]          var_second,
    input  logic [7:0]          covar,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          dissim_pixel,
    output logic                frame_done,
    output logic signed [17:0]  frame_mean,
    output logic signed [17:0]  frame_peak
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_TERMS = 13'b0000000000010,
        ST_TWAIT = 13'b0000000000100,
        ST_MULN  = 13'b0000000001000,
        ST_MULD  = 13'b0000000010000,
        ST_FRAC  = 13'b0000000100000,
        ST_FWAIT = 13'b0000001000000,
        ST_UPD   = 13'b0000010000000,
        ST_LDIV  = 13'b0000100000000,
        ST_LWAIT = 13'b0001000000000,
        ST_MDIV  = 13'b0010000000000,
        ST_MWAIT = 13'b0100000000000,
        ST_EMIT  = 13'b1000000000000
    } state_t;

    // configuration
    logic [12:0] width_reg, height_reg;
    logic [23:0] c1_reg, c2_reg;
    logic [12:0] width_eff, height_eff;

    // control
    state_t      state_reg, state_next;
    logic [1:0]  issue_reg, issue_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic signed [29:0] line_reg, line_next;
    logic signed [29:0] frame_reg, frame_next;
    logic signed [17:0] peak_reg, peak_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_done_reg, out_done_next;
    logic        res_done_reg, res_done_next;

    // payload
    logic [7:0]  m1_reg, m2_reg, v1_reg, v2_reg, cv_reg;
    logic [7:0]  m1_next, m2_next, v1_next, v2_next, cv_next;
    logic [24:0] p1_reg, q1_reg, p2_reg, q2_reg;
    logic [24:0] p1_next, q1_next, p2_next, q2_next;
    logic [49:0] num_reg, den_reg, num_next, den_next;
    logic signed [17:0] dq_reg, dq_next;
    logic        neg_reg, neg_next;
    logic [7:0]  res_pixel_reg, res_pixel_next;
    logic signed [17:0] res_mean_reg, res_mean_next;
    logic signed [17:0] res_peak_reg, res_peak_next;
    logic [7:0]  out_pixel_reg, out_pixel_next;
    logic signed [17:0] out_mean_reg, out_mean_next;
    logic signed [17:0] out_peak_reg, out_peak_next;

    // division chain
    sdm_pkg::div_job_t div_in;
    sdm_pkg::div_job_t div_out;

    // helpers
    logic [15:0] mm_prod, sq1, sq2;
    logic [16:0] x_p1, x_q1;
    logic [8:0]  x_p2, x_q2;
    logic [49:0] diff_le, diff_gt;
    logic        num_le;
    logic        frac_sat;
    logic [29:0] line_mag, frame_mag;
    logic [25:0] pix_prod;
    logic [17:0] frac_mag;
    logic [29:0] avg_val;
    logic signed [29:0] line_sum;
    logic        line_end, frame_end;

    // Clamp geometry: zero reads as one, oversize reads as the maximum.
    always_comb
    begin
        if (width_reg == 13'd0)
            width_eff = 13'd1;
        else if (width_reg > 13'(sdm_pkg::MAX_WIDTH))
            width_eff = 13'(sdm_pkg::MAX_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg == 13'd0)
            height_eff = 13'd1;
        else if (height_reg > 13'(sdm_pkg::MAX_HEIGHT))
            height_eff = 13'(sdm_pkg::MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    // Numerator and denominator pieces before scaling by 1/255 or 1/65025.
    always_comb
    begin
        mm_prod  = m1_reg * m2_reg;
        sq1      = m1_reg * m1_reg;
        sq2      = m2_reg * m2_reg;
        x_p1     = {mm_prod, 1'b0};
        x_q1     = {1'b0, sq1} + {1'b0, sq2};
        x_p2     = {cv_reg, 1'b0};
        x_q2     = {1'b0, v1_reg} + {1'b0, v2_reg};

        num_le   = (num_reg <= den_reg);
        diff_le  = den_reg - num_reg;
        diff_gt  = num_reg - den_reg;
        frac_sat = ({1'b0, diff_gt} >= {den_reg, 1'b0});

        line_mag  = line_reg[29]  ? 30'(-line_reg)  : 30'(line_reg);
        frame_mag = frame_reg[29] ? 30'(-frame_reg) : 30'(frame_reg);

        // dq * 255 / 65536 for positive dq
        pix_prod  = {1'b0, dq_reg[16:0], 8'b0} - {9'b0, dq_reg[16:0]};
        frac_mag  = {2'b0, div_out.quo[33:18]};
        avg_val   = div_out.quo[29:0];

        line_sum  = line_reg + 30'(dq_reg);
        line_end  = ({1'b0, col_reg} + 13'd1) >= width_eff;
        frame_end = ({1'b0, row_reg} + 13'd1) >= height_eff;
    end

    // Build the job handed to the division chain.
    always_comb
    begin
        div_in = '0;
        div_in.tag = sdm_pkg::TAG_P1;
        unique case (state_reg)
            ST_TERMS:
            begin
                div_in.valid = 1'b1;
                unique case (issue_reg)
                    2'd0:
                    begin
                        div_in.tag = sdm_pkg::TAG_P1;
                        div_in.dvd = {1'b0, x_p1, 16'b0};
                        div_in.dvs = sdm_pkg::TERM_MEAN_DIV;
                    end
                    2'd1:
                    begin
                        div_in.tag = sdm_pkg::TAG_Q1;
                        div_in.dvd = {1'b0, x_q1, 16'b0};
                        div_in.dvs = sdm_pkg::TERM_MEAN_DIV;
                    end
                    2'd2:
                    begin
                        div_in.tag = sdm_pkg::TAG_P2;
                        div_in.dvd = {9'b0, x_p2, 16'b0};
                        div_in.dvs = sdm_pkg::TERM_VAR_DIV;
                    end
                    default:
                    begin
                        div_in.tag = sdm_pkg::TAG_Q2;
                        div_in.dvd = {9'b0, x_q2, 16'b0};
                        div_in.dvs = sdm_pkg::TERM_VAR_DIV;
                    end
                endcase
            end
            ST_FRAC:
            begin
                div_in.tag = sdm_pkg::TAG_FRAC;
                div_in.dvs = {den_reg, 1'b0};
                if (den_reg != 50'd0)
                begin
                    if (num_le)
                    begin
                        div_in.valid = 1'b1;
                        div_in.rem   = {2'b0, diff_le};
                    end
                    else if (!frac_sat)
                    begin
                        div_in.valid = 1'b1;
                        div_in.rem   = {2'b0, diff_gt};
                    end
                end
            end
            ST_LDIV:
            begin
                div_in.valid = 1'b1;
                div_in.tag   = sdm_pkg::TAG_LINE;
                div_in.dvd   = {4'b0, line_mag};
                div_in.dvs   = {38'b0, width_eff};
            end
            ST_MDIV:
            begin
                div_in.valid = 1'b1;
                div_in.tag   = sdm_pkg::TAG_FRAME;
                div_in.dvd   = {4'b0, frame_mag};
                div_in.dvs   = {38'b0, height_eff};
            end
            default:
            begin
                div_in.valid = 1'b0;
            end
        endcase
    end

    sdm_div_chain u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .job_in  (div_in),
        .job_out (div_out)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        line_next      = line_reg;
        frame_next     = frame_reg;
        peak_next      = peak_reg;
        res_done_next  = res_done_reg;
        out_done_next  = out_done_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        cv_next        = cv_reg;
        p1_next        = p1_reg;
        q1_next        = q1_reg;
        p2_next        = p2_reg;
        q2_next        = q2_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        dq_next        = dq_reg;
        neg_next       = neg_reg;
        res_pixel_next = res_pixel_reg;
        res_mean_next  = res_mean_reg;
        res_peak_next  = res_peak_reg;
        out_pixel_next = out_pixel_reg;
        out_mean_next  = out_mean_reg;
        out_peak_next  = out_peak_reg;

        // drop the output item once taken
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    m1_next    = mean_first;
                    m2_next    = mean_second;
                    v1_next    = var_first;
                    v2_next    = var_second;
                    cv_next    = covar;
                    issue_next = 2'd0;
                    state_next = ST_TERMS;
                end
            end
            ST_TERMS:
            begin
                issue_next = issue_reg + 2'd1;
                if (issue_reg == 2'd3)
                    state_next = ST_TWAIT;
            end
            ST_TWAIT:
            begin
                if (div_out.valid)
                begin
                    unique case (div_out.tag)
                        sdm_pkg::TAG_P1:
                            p1_next = {7'b0, div_out.quo[17:0]} + {1'b0, c1_reg};
                        sdm_pkg::TAG_Q1:
                            q1_next = {7'b0, div_out.quo[17:0]} + {1'b0, c1_reg};
                        sdm_pkg::TAG_P2:
                            p2_next = {7'b0, div_out.quo[17:0]} + {1'b0, c2_reg};
                        sdm_pkg::TAG_Q2:
                        begin
                            q2_next    = {7'b0, div_out.quo[17:0]} + {1'b0, c2_reg};
                            state_next = ST_MULN;
                        end
                        default:
                            state_next = state_reg;
                    endcase
                end
            end
            ST_MULN:
            begin
                num_next   = p1_reg * p2_reg;
                state_next = ST_MULD;
            end
            ST_MULD:
            begin
                den_next   = q1_reg * q2_reg;
                state_next = ST_FRAC;
            end
            ST_FRAC:
            begin
                priority if (den_reg == 50'd0)
                begin
                    dq_next    = '0;
                    state_next = ST_UPD;
                end
                else if (num_le)
                begin
                    neg_next   = 1'b0;
                    state_next = ST_FWAIT;
                end
                else if (frac_sat)
                begin
                    dq_next    = sdm_pkg::PEAK_RESET;
                    state_next = ST_UPD;
                end
                else
                begin
                    neg_next   = 1'b1;
                    state_next = ST_FWAIT;
                end
            end
            ST_FWAIT:
            begin
                if (div_out.valid)
                begin
                    dq_next    = neg_reg ? -$signed(frac_mag) : $signed(frac_mag);
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                res_pixel_next = (dq_reg > 18'sd0) ? pix_prod[23:16] : 8'd0;
                line_next      = line_sum;
                if (dq_reg > peak_reg)
                    peak_next = dq_reg;
                if (line_end)
                begin
                    state_next = ST_LDIV;
                end
                else
                begin
                    col_next      = col_reg + 12'd1;
                    res_done_next = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_LDIV:
            begin
                state_next = ST_LWAIT;
            end
            ST_LWAIT:
            begin
                if (div_out.valid)
                begin
                    frame_next = frame_reg + (line_reg[29] ? -$signed(avg_val)
                                                           : $signed(avg_val));
                    line_next  = '0;
                    col_next   = '0;
                    if (frame_end)
                    begin
                        state_next = ST_MDIV;
                    end
                    else
                    begin
                        row_next      = row_reg + 12'd1;
                        res_done_next = 1'b0;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_MDIV:
            begin
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (div_out.valid)
                begin
                    res_mean_next = 18'(frame_reg[29] ? -$signed(avg_val)
                                                      : $signed(avg_val));
                    res_peak_next = peak_reg;
                    res_done_next = 1'b1;
                    // clear the frame state
                    col_next      = '0;
                    row_next      = '0;
                    line_next     = '0;
                    frame_next    = '0;
                    peak_next     = sdm_pkg::PEAK_RESET;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_done_next  = res_done_reg;
                    out_pixel_next = res_pixel_reg;
                    out_mean_next  = res_done_reg ? res_mean_reg : '0;
                    out_peak_next  = res_done_reg ? res_peak_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 13'd1;
            height_reg    <= 13'd1;
            c1_reg        <= 24'd426148;
            c2_reg        <= 24'd3835331;
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            line_reg      <= '0;
            frame_reg     <= '0;
            peak_reg      <= sdm_pkg::PEAK_RESET;
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
            res_done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (sdm_pkg::cfg_reg_t'(cfg_index))
                    sdm_pkg::REG_WIDTH:  width_reg  <= cfg_data[12:0];
                    sdm_pkg::REG_HEIGHT: height_reg <= cfg_data[12:0];
                    sdm_pkg::REG_C1:     c1_reg     <= cfg_data;
                    sdm_pkg::REG_C2:     c2_reg     <= cfg_data;
                    default:             c2_reg     <= c2_reg;
                endcase
            end
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            line_reg      <= line_next;
            frame_reg     <= frame_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            out_done_reg  <= out_done_next;
            res_done_reg  <= res_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg        <= m1_next;
        m2_reg        <= m2_next;
        v1_reg        <= v1_next;
        v2_reg        <= v2_next;
        cv_reg        <= cv_next;
        p1_reg        <= p1_next;
        q1_reg        <= q1_next;
        p2_reg        <= p2_next;
        q2_reg        <= q2_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        dq_reg        <= dq_next;
        neg_reg       <= neg_next;
        res_pixel_reg <= res_pixel_next;
        res_mean_reg  <= res_mean_next;
        res_peak_reg  <= res_peak_next;
        out_pixel_reg <= out_pixel_next;
        out_mean_reg  <= out_mean_next;
        out_peak_reg  <= out_peak_next;
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign dissim_pixel = out_pixel_reg;
    assign frame_done   = out_done_reg;
    assign frame_mean   = out_mean_reg;
    assign frame_peak   = out_peak_reg;

    `SDM_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_reg == ST_TERMS)
    `SDM_ASSERT_IMP(a_div_when_waiting, div_out.valid, state_reg == ST_TWAIT || state_reg == ST_FWAIT || state_reg == ST_LWAIT || state_reg == ST_MWAIT)
    `SDM_ASSERT_IMP(a_summary_zero, out_valid && !frame_done, frame_mean == 18'sd0 && frame_peak == 18'sd0)

endmodule
